// ----- rtl/sorted_key_table_macros.svh -----
// Assertion macros for the sorted key table checker.
`ifndef SORTED_KEY_TABLE_MACROS_SVH
`define SORTED_KEY_TABLE_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SKT_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SKT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/skt_pkg.sv -----
// Types, constants and codes of the sorted key table.
package skt_pkg;

  localparam int DEPTH        = 16;
  localparam int KEY_BITS     = 16;
  localparam int PAYLOAD_BITS = 32;
  localparam int CNT_W        = $clog2(DEPTH + 1);
  localparam int OCC_BITS     = 5;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } skt_state_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] item_key;
    logic [31:0] item_payload;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] out_key;
    logic [31:0] out_payload;
    logic [4:0]  occupancy;
  } skt_out_t;

  typedef struct packed {
    logic load;
    logic exec;
  } skt_cmd_t;

endpackage

// ----- rtl/skt_ctrl.sv -----
// Controller: transaction handshakes and the load/execute sequence.
module skt_ctrl import skt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output skt_cmd_t cmd_o
);

  skt_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    // drop the result once the transaction completes
    out_valid_d = out_valid_q && out_stall_i;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.exec  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- rtl/skt_dpath.sv -----
// Datapath: sorted row of entry cells with parallel compare and shift.
module skt_dpath import skt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  skt_cmd_t cmd_i,
  input  skt_in_t  in_data_i,
  output skt_out_t out_data_o
);

  logic [1:0]              op_q;
  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] pay_q;

  logic [KEY_BITS-1:0]     cell_key_q [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay_q [DEPTH];
  logic [KEY_BITS-1:0]     cell_key_d [DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay_d [DEPTH];
  logic [CNT_W-1:0]        count_q, count_d;
  skt_out_t                res_q, res_d;

  logic [DEPTH-1:0] valid, le, match, neg_match, first, after_m, sel, take_m;
  logic             full, empty, do_ins, do_take;
  logic [KEY_BITS-1:0]     sel_key;
  logic [PAYLOAD_BITS-1:0] sel_pay;

  // command register: latch the accepted transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= in_data_i.operation;
      key_q <= in_data_i.item_key[KEY_BITS-1:0];
      pay_q <= in_data_i.item_payload[PAYLOAD_BITS-1:0];
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = CNT_W'(i) < count_q;
      le[i]    = valid[i] && (cell_key_q[i] <= key_q);
      match[i] = valid[i] && (cell_key_q[i] == key_q);
    end
    // lowest match and everything from it upward
    neg_match = ~match + DEPTH'(1);
    first     = match & neg_match;
    after_m   = match | neg_match;

    full  = count_q == CNT_W'(DEPTH);
    empty = count_q == '0;

    sel    = (op_q == OP_POP) ? DEPTH'(1) : first;
    take_m = (op_q == OP_POP) ? '1 : after_m;

    sel_key = '0;
    sel_pay = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_key = sel_key | (cell_key_q[i] & {KEY_BITS{sel[i]}});
      sel_pay = sel_pay | (cell_pay_q[i] & {PAYLOAD_BITS{sel[i]}});
    end

    do_ins  = (op_q == OP_INSERT) && !full;
    do_take = ((op_q == OP_POP) && !empty) || ((op_q == OP_REMOVE) && (|match));

    res_d.status      = ST_OK;
    res_d.out_key     = '0;
    res_d.out_payload = '0;
    count_d           = count_q;
    if (op_q == OP_INSERT && full) begin
      res_d.status = ST_FULL;
    end else if ((op_q == OP_POP || op_q == OP_REMOVE) && empty) begin
      res_d.status = ST_EMPTY;
    end else if (op_q == OP_REMOVE && !(|match)) begin
      res_d.status = ST_NOT_FOUND;
    end
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_take) begin
      count_d           = count_q - CNT_W'(1);
      res_d.out_key     = 16'(sel_key);
      res_d.out_payload = 32'(sel_pay);
    end
    res_d.occupancy = OCC_BITS'(count_d);

    // insert: the first cell above the equal-or-smaller keys takes the new
    // entry, cells above it move up by one
    cell_key_d[0] = le[0] ? cell_key_q[0] : key_q;
    cell_pay_d[0] = le[0] ? cell_pay_q[0] : pay_q;
    for (int i = 1; i < DEPTH; i++) begin
      if (le[i]) begin
        cell_key_d[i] = cell_key_q[i];
        cell_pay_d[i] = cell_pay_q[i];
      end else if (le[i-1]) begin
        cell_key_d[i] = key_q;
        cell_pay_d[i] = pay_q;
      end else begin
        cell_key_d[i] = cell_key_q[i-1];
        cell_pay_d[i] = cell_pay_q[i-1];
      end
    end
    // removal: cells from the removed one upward move down by one
    if (!do_ins) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_key_d[i] = cell_key_q[i];
        cell_pay_d[i] = cell_pay_q[i];
      end
      for (int i = 0; i < DEPTH - 1; i++) begin
        if (take_m[i]) begin
          cell_key_d[i] = cell_key_q[i+1];
          cell_pay_d[i] = cell_pay_q[i+1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (do_ins || do_take)) begin
      for (int i = 0; i < DEPTH; i++) begin
        cell_key_q[i] <= cell_key_d[i];
        cell_pay_q[i] <= cell_pay_d[i];
      end
    end
    if (cmd_i.exec) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign out_data_o = res_q;

endmodule

// ----- rtl/sorted_key_table.sv -----
// A transaction is latched in the command register, then executed into the result register.
// The block takes a new transaction only after the current one has executed; a held result delays the execute step.
// Each execute step compares all DEPTH cells in parallel and shifts the row once.
// Reset clears the entry count and the result valid; cell contents are not cleared.
// The block takes transactions from the first cycle after reset.
module sorted_key_table import skt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  skt_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output skt_out_t out_data_o
);

  skt_cmd_t cmd;

  skt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  skt_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule

// ----- rtl/skt_checker.sv -----
// Port-level checker for the sorted key table, bound to the top level.
`include "sorted_key_table_macros.svh"

module skt_checker import skt_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input skt_out_t out_data_o
);

  localparam logic [OCC_BITS-1:0] OCC_MAX = OCC_BITS'(DEPTH);

  logic                in_take;
  logic                out_hold;
  logic                full_res;
  logic                key_zero;
  logic [OCC_BITS-1:0] occ;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_hold = out_valid_o && out_stall_i;
  assign full_res = out_valid_o && (out_data_o.status == ST_FULL);
  assign key_zero = out_data_o.out_key == '0;
  assign occ      = out_data_o.occupancy;

  `SKT_ASSERT(a_out_hold, out_hold |=> out_valid_o && $stable(out_data_o), "held result changed")
  `SKT_ASSERT(a_one_at_a_time, in_take |=> in_stall_o, "second transaction taken while busy")
  `SKT_ASSERT(a_occ_bound, out_valid_o |-> occ <= OCC_MAX, "occupancy above depth")
  `SKT_ASSERT(a_full_occ, full_res |-> occ == OCC_MAX && key_zero, "full reported below depth")
  // reset clears the result valid
  `SKT_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> !out_valid_o, "result valid during reset")

endmodule

bind sorted_key_table skt_checker u_skt_checker (.*);
